/* rtl/owtr_pkg.sv */
// ----------------------------------------------------------------------------
// owtr_pkg - shared types and constants of the 1-Wire temperature reader
// Timing register map, command bytes and the per-tick result layout.
// ----------------------------------------------------------------------------
package owtr_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int TIMER_W     = 16;
  localparam int TEMP_W      = 16;

  // timing register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RESET_LOW     = 4'd0,
    CFG_PRESENCE_WAIT = 4'd1,
    CFG_RESET_TAIL    = 4'd2,
    CFG_RECOVERY      = 4'd3,
    CFG_WRITE_LOW     = 4'd4,
    CFG_SLOT_HOLD     = 4'd5,
    CFG_READ_LOW      = 4'd6,
    CFG_READ_RELEASE  = 4'd7
  } cfg_index_t;

  localparam logic [13:0] RESET_LOW_DEF     = 14'd700;
  localparam logic [9:0]  PRESENCE_WAIT_DEF = 10'd75;
  localparam logic [9:0]  RESET_TAIL_DEF    = 10'd495;
  localparam logic [15:0] RECOVERY_DEF      = 16'd10000;
  localparam logic [5:0]  WRITE_LOW_DEF     = 6'd3;
  localparam logic [7:0]  SLOT_HOLD_DEF     = 8'd60;
  localparam logic [5:0]  READ_LOW_DEF      = 6'd5;
  localparam logic [5:0]  READ_RELEASE_DEF  = 6'd10;

  typedef struct packed {
    logic [13:0] reset_low_us;
    logic [9:0]  presence_wait_us;
    logic [9:0]  reset_tail_us;
    logic [15:0] recovery_us;
    logic [5:0]  write_low_us;
    logic [7:0]  slot_hold_us;
    logic [5:0]  read_low_us;
    logic [5:0]  read_release_us;
  } timing_t;

  // sequence steps
  localparam logic [2:0] STEP_RESET_A  = 3'd0;
  localparam logic [2:0] STEP_SKIP_A   = 3'd1;
  localparam logic [2:0] STEP_CONVERT  = 3'd2;
  localparam logic [2:0] STEP_RESET_B  = 3'd3;
  localparam logic [2:0] STEP_SKIP_B   = 3'd4;
  localparam logic [2:0] STEP_READ_CMD = 3'd5;
  localparam logic [2:0] STEP_READ_LO  = 3'd6;
  localparam logic [2:0] STEP_READ_HI  = 3'd7;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hBE;

  function automatic logic [7:0] cmd_byte(input logic [2:0] step);
    logic [7:0] b;
    case (step)
      STEP_SKIP_A, STEP_SKIP_B: b = CMD_SKIP_ROM;
      STEP_CONVERT:             b = CMD_CONVERT;
      STEP_READ_CMD:            b = CMD_READ_SP;
      default:                  b = 8'h00;
    endcase
    return b;
  endfunction

  // one tick's result, drive_enable in bit 0
  typedef struct packed {
    logic              presence_ok;
    logic [TEMP_W-1:0] temperature_raw;
    logic              done_res;
    logic              busy_res;
    logic              drive_level;
    logic              drive_enable;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

/* rtl/owtr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// owtr_cfg_regs - timing register file
// Holds the eight slot timings; writes past the map are dropped.
// ----------------------------------------------------------------------------
module owtr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [owtr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output owtr_pkg::timing_t                timing
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.reset_low_us     <= owtr_pkg::RESET_LOW_DEF;
      timing.presence_wait_us <= owtr_pkg::PRESENCE_WAIT_DEF;
      timing.reset_tail_us    <= owtr_pkg::RESET_TAIL_DEF;
      timing.recovery_us      <= owtr_pkg::RECOVERY_DEF;
      timing.write_low_us     <= owtr_pkg::WRITE_LOW_DEF;
      timing.slot_hold_us     <= owtr_pkg::SLOT_HOLD_DEF;
      timing.read_low_us      <= owtr_pkg::READ_LOW_DEF;
      timing.read_release_us  <= owtr_pkg::READ_RELEASE_DEF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        owtr_pkg::CFG_RESET_LOW:     timing.reset_low_us     <= cfg_data[13:0];
        owtr_pkg::CFG_PRESENCE_WAIT: timing.presence_wait_us <= cfg_data[9:0];
        owtr_pkg::CFG_RESET_TAIL:    timing.reset_tail_us    <= cfg_data[9:0];
        owtr_pkg::CFG_RECOVERY:      timing.recovery_us      <= cfg_data;
        owtr_pkg::CFG_WRITE_LOW:     timing.write_low_us     <= cfg_data[5:0];
        owtr_pkg::CFG_SLOT_HOLD:     timing.slot_hold_us     <= cfg_data[7:0];
        owtr_pkg::CFG_READ_LOW:      timing.read_low_us      <= cfg_data[5:0];
        owtr_pkg::CFG_READ_RELEASE:  timing.read_release_us  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/owtr_seq.sv */
// ----------------------------------------------------------------------------
// owtr_seq - 1-Wire bus sequencer
// Steps once per accepted tick; result reflects the phase before the step.
// ----------------------------------------------------------------------------
module owtr_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    start_req,
  input  logic                    line_sample,
  input  owtr_pkg::timing_t       timing,
  output owtr_pkg::result_t       result
);

  typedef enum logic [3:0] {
    P_IDLE, P_RST_LOW, P_RST_REL, P_RST_TAIL, P_RECOV,
    P_WR_LOW, P_WR_HOLD, P_RD_LOW, P_RD_REL, P_RD_TAIL, P_DONE
  } phase_t;

  phase_t                         phase, phase_next;
  logic [owtr_pkg::TIMER_W-1:0]   tick_timer, tick_timer_next;
  logic [2:0]                     bit_index, bit_index_next;
  logic [2:0]                     step_index, step_index_next;
  logic [owtr_pkg::TEMP_W-1:0]    read_shift, read_shift_next;
  logic [owtr_pkg::TEMP_W-1:0]    held_result, held_result_next;
  logic                           presence_flag, presence_flag_next;

  logic [owtr_pkg::TIMER_W-1:0]   len, dur;
  logic                           more;
  logic [7:0]                     cmd_now;
  logic                           wbit;
  logic [2:0]                     step_inc;
  phase_t                         step_first, slot_first;

  assign cmd_now  = owtr_pkg::cmd_byte(step_index);
  assign wbit     = cmd_now[bit_index];
  assign step_inc = step_index + 3'd1;

  // result from the phase at the start of the tick
  always_comb begin
    result.drive_enable    = 1'b1;
    result.drive_level     = 1'b1;
    case (phase)
      P_RST_LOW, P_WR_LOW, P_RD_LOW: result.drive_level  = 1'b0;
      P_WR_HOLD:                     result.drive_level  = wbit;
      P_RST_TAIL, P_RD_TAIL:         result.drive_enable = 1'b0;
      default: ;
    endcase
    result.busy_res        = (phase != P_IDLE) && (phase != P_DONE);
    result.done_res        = (phase == P_DONE);
    result.temperature_raw = held_result;
    result.presence_ok     = presence_flag;
  end

  always_comb begin
    case (phase)
      P_RST_LOW:  len = {2'b0, timing.reset_low_us};
      P_RST_REL:  len = {6'b0, timing.presence_wait_us};
      P_RST_TAIL: len = {6'b0, timing.reset_tail_us};
      P_RECOV:    len = timing.recovery_us;
      P_WR_LOW:   len = {10'b0, timing.write_low_us};
      P_WR_HOLD,
      P_RD_TAIL:  len = {8'b0, timing.slot_hold_us};
      P_RD_LOW:   len = {10'b0, timing.read_low_us};
      P_RD_REL:   len = {10'b0, timing.read_release_us};
      default:    len = '0;
    endcase
    dur  = (len == '0) ? owtr_pkg::TIMER_W'(1) : len;
    more = ({1'b0, tick_timer} + 17'd1) < {1'b0, dur};
  end

  // first phase of the following step, and of a following bit
  always_comb begin
    if (step_inc == owtr_pkg::STEP_RESET_B)
      step_first = P_RST_LOW;
    else if (step_inc >= owtr_pkg::STEP_READ_LO)
      step_first = P_RD_LOW;
    else
      step_first = P_WR_LOW;
    slot_first = (step_index >= owtr_pkg::STEP_READ_LO) ? P_RD_LOW : P_WR_LOW;
  end

  always_comb begin
    phase_next         = phase;
    tick_timer_next    = tick_timer;
    bit_index_next     = bit_index;
    step_index_next    = step_index;
    read_shift_next    = read_shift;
    held_result_next   = held_result;
    presence_flag_next = presence_flag;
    if (adv) begin
      if (phase == P_RST_TAIL && tick_timer == '0 &&
          step_index == owtr_pkg::STEP_RESET_A)
        presence_flag_next = !line_sample;
      if (phase == P_RD_TAIL && tick_timer == '0)
        read_shift_next = {line_sample, read_shift[owtr_pkg::TEMP_W-1:1]};
      case (phase)
        P_IDLE: begin
          if (start_req) begin
            step_index_next = '0;
            bit_index_next  = '0;
            read_shift_next = '0;
            tick_timer_next = '0;
            phase_next      = P_RST_LOW;
          end
        end
        P_DONE: begin
          tick_timer_next = '0;
          phase_next      = P_IDLE;
        end
        default: begin
          if (more) begin
            tick_timer_next = tick_timer + owtr_pkg::TIMER_W'(1);
          end else begin
            tick_timer_next = '0;
            case (phase)
              P_RST_LOW:  phase_next = P_RST_REL;
              P_RST_REL:  phase_next = P_RST_TAIL;
              P_RST_TAIL: phase_next = P_RECOV;
              P_WR_LOW:   phase_next = P_WR_HOLD;
              P_RD_LOW:   phase_next = P_RD_REL;
              P_RD_REL:   phase_next = P_RD_TAIL;
              default: begin
                // recovery ends a step; hold and read tail end a bit
                if (phase == P_RECOV || bit_index == 3'd7) begin
                  bit_index_next = '0;
                  if (step_index == owtr_pkg::STEP_READ_HI) begin
                    held_result_next = read_shift_next;
                    step_index_next  = '0;
                    phase_next       = P_DONE;
                  end else begin
                    step_index_next = step_inc;
                    phase_next      = step_first;
                  end
                end else begin
                  bit_index_next = bit_index + 3'd1;
                  phase_next     = slot_first;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= P_IDLE;
      tick_timer    <= '0;
      bit_index     <= '0;
      step_index    <= '0;
      read_shift    <= '0;
      held_result   <= '0;
      presence_flag <= 1'b0;
    end else begin
      phase         <= phase_next;
      tick_timer    <= tick_timer_next;
      bit_index     <= bit_index_next;
      step_index    <= step_index_next;
      read_shift    <= read_shift_next;
      held_result   <= held_result_next;
      presence_flag <= presence_flag_next;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (adv && phase == P_DONE) |=> (phase == P_IDLE))
    else $error("done tick not followed by idle");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == P_IDLE) |-> (step_index == 3'd0 && bit_index == 3'd0))
    else $error("idle with stale step or bit index");

  a_presence: assert property (@(posedge clk) disable iff (rst)
    (adv && phase == P_RST_TAIL && tick_timer == '0 &&
     step_index == owtr_pkg::STEP_RESET_A) |=> (presence_flag == !$past(line_sample)))
    else $error("presence flag not taken from first reset sample");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (adv && phase != P_RD_TAIL) |=> $stable(held_result))
    else $error("result changed outside the last read slot");

endmodule

/* rtl/onewire_temperature_reader_core.sv */
// ----------------------------------------------------------------------------
// onewire_temperature_reader_core - 1-Wire master reading one sensor
// Runs reset/presence, Skip ROM + Convert T, reset, Skip ROM + Read
// Scratchpad, then reads the two temperature bytes, one tick at a time.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                    transfer when
//   s_*      in   tick: start_req, line_sample               s_tvalid & s_tready
//   m_*      out  pin drive, busy, done, temperature, pres.  m_tvalid & m_tready
//   cfg_*    in   timing register index + value              cfg_valid & cfg_ready
//
// Each tick transfer gives one result transfer; one tick per clock with m_tready high.
// The sequencer steps on the accepting edge, which also loads the result
// register; the result is offered on m_* from the next cycle.
// s_tready = !m_tvalid || m_tready: a stalled m side holds one result and
// then backpressures the input. Reset returns the sequencer to idle (pin
// high), clears result and presence, restores default timings; cfg_ready is high.
//
module onewire_temperature_reader_core (
  input  logic                             clk,
  input  logic                             rst,
  // tick input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [0] start_req, [1] line_sample
  // per-tick result
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] drive_enable, [1] drive_level, [2] busy_res, [3] done_res,
  // [19:4] temperature_raw, [20] presence_ok, rest zero
  output logic [owtr_pkg::M_DATA_W-1:0]    m_tdata,
  // timing register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [owtr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  owtr_pkg::timing_t timing;
  owtr_pkg::result_t result;
  logic              adv;

  // a tick is taken whenever the output register can accept its result
  assign s_tready = !m_tvalid || m_tready;
  assign adv      = s_tvalid && s_tready;

  owtr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  owtr_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .start_req   (s_tdata[0]),
    .line_sample (s_tdata[1]),
    .timing      (timing),
    .result      (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= owtr_pkg::M_DATA_W'(result);
    end
  end

  a_load_on_transfer: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_tvalid)
    else $error("accepted tick produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[owtr_pkg::M_DATA_W-1:owtr_pkg::RESULT_W] == '0))
    else $error("result padding not zero");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for the 1-Wire temperature reader core
// Each tick transfer is run through a bit-accurate sequencer model kept in
// the bench. Every result transfer is checked against the oldest prediction.
// A short directed table covers register extremes, width masking, mid-phase
// retiming, the presence sample and ignored writes. Random phases then run
// complete read sequences under the different stall patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_PHASES    = 8;
  localparam int TICKS_PER_PHASE  = 210;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int REPORT_LIMIT     = 10;

  // any index past the register map; such writes must be dropped
  localparam logic [owtr_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED =
    owtr_pkg::CFG_INDEX_W'(owtr_pkg::CFG_READ_RELEASE + 4);
  localparam logic [7:0] NO_CMD = 8'h00;
  localparam int REG_WIDTH [8] = '{14, 10, 10, 16, 6, 8, 6, 6};

  typedef enum logic [3:0] {
    ST_IDLE, ST_RST_LOW, ST_RST_REL, ST_RST_TAIL, ST_RECOV,
    ST_WR_LOW, ST_WR_HOLD, ST_RD_LOW, ST_RD_REL, ST_RD_TAIL, ST_DONE
  } seq_phase_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [owtr_pkg::CFG_INDEX_W-1:0] reg_idx;
    logic [owtr_pkg::CFG_DATA_W-1:0]  reg_data;
    logic                             start;
    logic                             line;
    logic [3:0]                       reps;
    logic                             known;      // use known_res instead of the model
    owtr_pkg::result_t                known_res;
  } plan_row_t;

  localparam owtr_pkg::result_t NO_CHECK   = '0;
  // idle after reset: pin driven high, nothing latched
  localparam owtr_pkg::result_t IDLE_CLEAR = '{presence_ok: 1'b0, temperature_raw: '0,
                                               done_res: 1'b0, busy_res: 1'b0,
                                               drive_level: 1'b1, drive_enable: 1'b1};
  // first tick of the reset pulse
  localparam owtr_pkg::result_t PULSE_LOW  = '{presence_ok: 1'b0, temperature_raw: '0,
                                               done_res: 1'b0, busy_res: 1'b1,
                                               drive_level: 1'b0, drive_enable: 1'b1};

  // directed walk through the first reset and into the first write slot
  localparam plan_row_t PLAN [30] = '{
    '{ROW_TICK,  '0, '0, 1'b0, 1'b1, 4'd2, 1'b1, IDLE_CLEAR},
    // start tick still reports idle
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, 4'd1, 1'b1, IDLE_CLEAR},
    // start while busy: ignored
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, 4'd1, 1'b1, PULSE_LOW},
    // masks to max
    '{ROW_WRITE, owtr_pkg::CFG_RESET_LOW, 16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b1, 4'd2, 1'b0, NO_CHECK},
    // already past it
    '{ROW_WRITE, owtr_pkg::CFG_RESET_LOW, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b1, 4'd1, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_PRESENCE_WAIT, 16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b0, 4'd2, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_PRESENCE_WAIT, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b0, 4'd1, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_RESET_TAIL, 16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    // line low at sample: present
    '{ROW_TICK,  '0, '0, 1'b1, 1'b0, 4'd2, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_RESET_TAIL, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b1, 4'd1, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_RECOVERY, 16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b1, 4'd2, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_RECOVERY, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b1, 4'd1, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_WRITE_LOW, 16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_SLOT_HOLD, 16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_READ_LOW, 16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_READ_RELEASE, 16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b1, 4'd3, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_WRITE_LOW, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_SLOT_HOLD, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_READ_LOW, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_WRITE, owtr_pkg::CFG_READ_RELEASE, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_WRITE, CFG_UNMAPPED, 16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0, NO_CHECK},
    '{ROW_TICK,  '0, '0, 1'b0, 1'b1, 4'd3, 1'b0, NO_CHECK}
  };

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [7:0]                       s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [owtr_pkg::M_DATA_W-1:0]    m_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [owtr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // sequencer model state
  owtr_pkg::timing_t timing_now;
  seq_phase_t        seq_phase;
  logic [15:0]       slot_timer;
  logic [2:0]        bit_pos;
  logic [2:0]        step_pos;
  logic [15:0]       shift_in;
  logic [15:0]       held_temp;
  logic              presence_seen;
  logic [7:0]        step_cmd [8] = '{NO_CMD, owtr_pkg::CMD_SKIP_ROM, owtr_pkg::CMD_CONVERT,
                                      NO_CMD, owtr_pkg::CMD_SKIP_ROM, owtr_pkg::CMD_READ_SP,
                                      NO_CMD, NO_CMD};

  owtr_pkg::result_t due_results [$];
  int unsigned       bad_results = 0;
  int unsigned       cycle_count = 0;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_stall_pct = 0;
  int unsigned       hold_req = 0;
  int unsigned       hold_ack = 0;
  int unsigned       hold_left = 0;
  owtr_pkg::result_t seen_res;
  owtr_pkg::result_t want_res;

  onewire_temperature_reader_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---- model ---------------------------------------------------------------

  // step done: move to the next command step, or latch the result after
  // the high temperature byte
  function automatic void close_step();
    bit_pos = '0;
    if (step_pos == owtr_pkg::STEP_READ_HI) begin
      held_temp = shift_in;
      step_pos  = owtr_pkg::STEP_RESET_A;
      seq_phase = ST_DONE;
    end else begin
      step_pos = step_pos + 1'b1;
      if (step_pos == owtr_pkg::STEP_RESET_B)
        seq_phase = ST_RST_LOW;
      else if (step_pos >= owtr_pkg::STEP_READ_LO)
        seq_phase = ST_RD_LOW;
      else
        seq_phase = ST_WR_LOW;
    end
  endfunction

  // one bus tick: outputs come from the phase at the start of the tick
  function automatic owtr_pkg::result_t sequence_tick(input logic start, input logic line);
    owtr_pkg::result_t r;
    int unsigned       span;
    r.drive_enable = 1'b1;
    r.drive_level  = 1'b1;
    case (seq_phase)
      ST_RST_LOW, ST_WR_LOW, ST_RD_LOW: r.drive_level = 1'b0;
      ST_WR_HOLD: r.drive_level = step_cmd[step_pos][bit_pos];
      ST_RST_TAIL, ST_RD_TAIL: r.drive_enable = 1'b0;
      default: ;
    endcase
    r.busy_res        = (seq_phase != ST_IDLE) && (seq_phase != ST_DONE);
    r.done_res        = (seq_phase == ST_DONE);
    r.temperature_raw = held_temp;
    r.presence_ok     = presence_seen;

    span = 1;
    case (seq_phase)
      ST_IDLE: begin
        if (start) begin
          step_pos   = owtr_pkg::STEP_RESET_A;
          bit_pos    = '0;
          shift_in   = '0;
          slot_timer = '0;
          seq_phase  = ST_RST_LOW;
        end
        return r;
      end
      ST_DONE: begin
        slot_timer = '0;
        seq_phase  = ST_IDLE;
        return r;
      end
      ST_RST_LOW: span = timing_now.reset_low_us;
      ST_RST_REL: span = timing_now.presence_wait_us;
      ST_RST_TAIL: begin
        // only the first reset records presence
        if (slot_timer == 0 && step_pos == owtr_pkg::STEP_RESET_A)
          presence_seen = !line;
        span = timing_now.reset_tail_us;
      end
      ST_RECOV:   span = timing_now.recovery_us;
      ST_WR_LOW:  span = timing_now.write_low_us;
      ST_WR_HOLD: span = timing_now.slot_hold_us;
      ST_RD_LOW:  span = timing_now.read_low_us;
      ST_RD_REL:  span = timing_now.read_release_us;
      default: begin
        if (slot_timer == 0)
          shift_in = {line, shift_in[15:1]};
        span = timing_now.slot_hold_us;
      end
    endcase

    if (span == 0)
      span = 1;
    if (slot_timer + 1 < span) begin
      slot_timer = slot_timer + 1'b1;
      return r;
    end
    slot_timer = '0;
    case (seq_phase)
      ST_RST_LOW:  seq_phase = ST_RST_REL;
      ST_RST_REL:  seq_phase = ST_RST_TAIL;
      ST_RST_TAIL: seq_phase = ST_RECOV;
      ST_RECOV:    close_step();
      ST_WR_LOW:   seq_phase = ST_WR_HOLD;
      ST_RD_LOW:   seq_phase = ST_RD_REL;
      ST_RD_REL:   seq_phase = ST_RD_TAIL;
      default: begin
        // end of a write hold or read tail
        if (&bit_pos) begin
          close_step();
        end else begin
          bit_pos   = bit_pos + 1'b1;
          seq_phase = (step_pos >= owtr_pkg::STEP_READ_LO) ? ST_RD_LOW : ST_WR_LOW;
        end
      end
    endcase
    return r;
  endfunction

  // ---- drivers -------------------------------------------------------------

  task automatic set_idle_mode(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  // hold ticks back until every predicted result has been taken
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0)
      @(posedge clk);
  endtask

  // cfg_valid stays up after the transfer; the next tick lowers it
  task automatic write_timing(input logic [owtr_pkg::CFG_INDEX_W-1:0] idx,
                              input logic [owtr_pkg::CFG_DATA_W-1:0] data);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      owtr_pkg::CFG_RESET_LOW:     timing_now.reset_low_us     = data[13:0];
      owtr_pkg::CFG_PRESENCE_WAIT: timing_now.presence_wait_us = data[9:0];
      owtr_pkg::CFG_RESET_TAIL:    timing_now.reset_tail_us    = data[9:0];
      owtr_pkg::CFG_RECOVERY:      timing_now.recovery_us      = data[15:0];
      owtr_pkg::CFG_WRITE_LOW:     timing_now.write_low_us     = data[5:0];
      owtr_pkg::CFG_SLOT_HOLD:     timing_now.slot_hold_us     = data[7:0];
      owtr_pkg::CFG_READ_LOW:      timing_now.read_low_us      = data[5:0];
      owtr_pkg::CFG_READ_RELEASE:  timing_now.read_release_us  = data[5:0];
      default: ;
    endcase
  endtask

  task automatic send_tick(input logic start, input logic line,
                           input logic known, input owtr_pkg::result_t known_res);
    owtr_pkg::result_t predicted;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, line, start};
    do @(posedge clk); while (!s_tready);
    predicted = sequence_tick(start, line);
    due_results.push_back(known ? known_res : predicted);
  endtask

  // short timings so that full sequences complete; upper bits beyond each
  // register's width are random and must be masked off
  task automatic program_random_timing();
    logic [owtr_pkg::CFG_DATA_W-1:0] value;
    for (int i = owtr_pkg::CFG_RESET_LOW; i <= owtr_pkg::CFG_READ_RELEASE; i++) begin
      value = ($urandom_range(7) == 0) ? owtr_pkg::CFG_DATA_W'($urandom_range(9, 3))
                                       : owtr_pkg::CFG_DATA_W'($urandom_range(2));
      value = value | (owtr_pkg::CFG_DATA_W'($urandom) << REG_WIDTH[i]);
      write_timing(owtr_pkg::CFG_INDEX_W'(i), value);
    end
    if ($urandom_range(1))
      write_timing(owtr_pkg::CFG_INDEX_W'($urandom_range((1 << owtr_pkg::CFG_INDEX_W) - 1,
                                                         CFG_UNMAPPED)),
                   owtr_pkg::CFG_DATA_W'($urandom));
  endtask

  // ---- result side ---------------------------------------------------------

  // random stalls, or a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_res = owtr_pkg::result_t'(m_tdata[owtr_pkg::RESULT_W-1:0]);
      if (due_results.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_LIMIT)
          $display("unexpected result transfer: %h", m_tdata);
      end else begin
        want_res = due_results.pop_front();
        if (seen_res.drive_enable !== want_res.drive_enable ||
            seen_res.drive_level !== want_res.drive_level ||
            seen_res.busy_res !== want_res.busy_res ||
            seen_res.done_res !== want_res.done_res ||
            seen_res.temperature_raw !== want_res.temperature_raw ||
            seen_res.presence_ok !== want_res.presence_ok ||
            m_tdata[owtr_pkg::M_DATA_W-1:owtr_pkg::RESULT_W] !== '0) begin
          bad_results++;
          if (bad_results <= REPORT_LIMIT) begin
            $display("result mismatch: expected en=%b lvl=%b busy=%b done=%b temp=%h pres=%b",
                     want_res.drive_enable, want_res.drive_level, want_res.busy_res,
                     want_res.done_res, want_res.temperature_raw, want_res.presence_ok);
            $display("                 got en=%b lvl=%b busy=%b done=%b temp=%h pres=%b pad=%h",
                     seen_res.drive_enable, seen_res.drive_level, seen_res.busy_res,
                     seen_res.done_res, seen_res.temperature_raw, seen_res.presence_ok,
                     m_tdata[owtr_pkg::M_DATA_W-1:owtr_pkg::RESULT_W]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---- stimulus ------------------------------------------------------------

  initial begin
    int unsigned line_pattern;
    logic        line_bit;
    timing_now = '{owtr_pkg::RESET_LOW_DEF, owtr_pkg::PRESENCE_WAIT_DEF,
                   owtr_pkg::RESET_TAIL_DEF, owtr_pkg::RECOVERY_DEF,
                   owtr_pkg::WRITE_LOW_DEF, owtr_pkg::SLOT_HOLD_DEF,
                   owtr_pkg::READ_LOW_DEF, owtr_pkg::READ_RELEASE_DEF};
    seq_phase     = ST_IDLE;
    slot_timer    = '0;
    bit_pos       = '0;
    step_pos      = owtr_pkg::STEP_RESET_A;
    shift_in      = '0;
    held_temp     = '0;
    presence_seen = 1'b0;
    set_idle_mode(0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_WRITE)
        write_timing(PLAN[i].reg_idx, PLAN[i].reg_data);
      else
        repeat (PLAN[i].reps)
          send_tick(PLAN[i].start, PLAN[i].line, PLAN[i].known, PLAN[i].known_res);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_random_timing();
      case (ph % 4)
        0:       set_idle_mode(0, 0);
        1:       set_idle_mode(76, 0);
        2:       set_idle_mode(0, 76);
        default: set_idle_mode(38, 38);
      endcase
      // all-low reads give zero and presence, all-high give 0xFFFF
      line_pattern = $urandom_range(3);
      // result side stops for a while, ticks keep coming and back up
      if (ph == 0)
        hold_req <= hold_req + 1;
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (ph == 1 && n == TICKS_PER_PHASE / 2)
          wait_results_drained();
        case (line_pattern)
          0:       line_bit = 1'b0;
          1:       line_bit = 1'b1;
          default: line_bit = logic'($urandom_range(1));
        endcase
        send_tick(logic'($urandom_range(1)), line_bit, 1'b0, NO_CHECK);
      end
    end

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (bad_results == 0 && due_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
